/* rtl/bbs_pkg.sv */
// Package for the two-axis bang-bang steering block.
// Holds payload structs, the axis-unit request/result structs and the reset constants.
// No dependencies.
`timescale 1ns / 1ps

package bbs_pkg;

    localparam int ITER_LIMIT_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [30:0] TIME_STEP_RST = 31'd655;
    localparam logic [30:0] MAX_ACCEL_RST = 31'd65536;

    localparam logic REG_TIME_STEP = 1'b0;
    localparam logic REG_MAX_ACCEL = 1'b1;

    typedef struct packed {
        logic signed [31:0] start_pos_x;
        logic signed [31:0] start_pos_y;
        logic signed [31:0] start_vel_x;
        logic signed [31:0] start_vel_y;
        logic signed [31:0] goal_pos_x;
        logic signed [31:0] goal_pos_y;
        logic signed [31:0] goal_vel_x;
        logic signed [31:0] goal_vel_y;
    } in_item_t;

    typedef struct packed {
        logic [30:0]        segment_duration;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic               last_segment;
        logic [1:0]         status;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sv;
        logic signed [31:0] gx;
        logic signed [31:0] gv;
        logic [30:0]        acc;
        logic [30:0]        dt;
    } axis_req_t;

    typedef struct packed {
        logic        dir;
        logic [63:0] ts;
        logic [63:0] tg;
    } axis_res_t;

endpackage

/* rtl/bbs_axis.sv */
// Switch and brake times for one axis: shared multiplier, square-root and divide steps.
// Depends on bbs_pkg.
`timescale 1ns / 1ps

module bbs_axis #(
    parameter int FRAC_BITS = bbs_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bbs_pkg::axis_req_t req,
    output logic              done,
    output bbs_pkg::axis_res_t res
);

    localparam logic [3:0] A_IDLE = 4'd0;
    localparam logic [3:0] A_SQ1  = 4'd1;
    localparam logic [3:0] A_SQ2  = 4'd2;
    localparam logic [3:0] A_AD   = 4'd3;
    localparam logic [3:0] A_RAD  = 4'd4;
    localparam logic [3:0] A_SQRT = 4'd5;
    localparam logic [3:0] A_NUM  = 4'd6;
    localparam logic [3:0] A_DIV  = 4'd7;
    localparam logic [3:0] A_DONE = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [63:0] s2_reg, g2_reg, ad_reg, half_reg;
    logic [63:0] x_reg, sq_reg;
    logic [4:0]  k_reg;
    logic [33:0] n2_reg;
    logic [63:0] num_reg, q_reg, t_reg;
    logic [30:0] den_reg, rem_reg;
    logic [5:0]  cnt_reg;
    logic [1:0]  dsel_reg;
    logic [63:0] ts_reg, tg_reg;

    logic        dir;
    logic [32:0] dwide;
    logic [31:0] dpos, svabs, gvabs;
    logic [32:0] svneg, gvneg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [5:0]  sh;
    logic [63:0] bitv, trial;
    logic [33:0] peak;
    logic [34:0] e1, e2;
    logic [33:0] n1, n2;
    logic [31:0] rtrial;
    logic        ge;
    logic [30:0] rem_n;
    logic [63:0] q_n;

    assign dir   = req.sx < req.gx;
    assign dwide = dir ? ({req.gx[31], req.gx} - {req.sx[31], req.sx})
                       : ({req.sx[31], req.sx} - {req.gx[31], req.gx});
    assign dpos  = dwide[31:0];
    assign svneg = 33'd0 - {req.sv[31], req.sv};
    assign gvneg = 33'd0 - {req.gv[31], req.gv};
    assign svabs = req.sv[31] ? svneg[31:0] : req.sv;
    assign gvabs = req.gv[31] ? gvneg[31:0] : req.gv;

    always_comb
    begin
        case (state_reg)
            A_SQ1:
            begin
                mul_a = svabs;
                mul_b = svabs;
            end
            A_SQ2:
            begin
                mul_a = gvabs;
                mul_b = gvabs;
            end
            default:
            begin
                mul_a = {1'b0, req.acc};
                mul_b = dpos;
            end
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign sh    = 6'd62 - {k_reg, 1'b0};
    assign bitv  = 64'd1 << sh;
    assign trial = sq_reg + bitv;

    assign peak = dir ? {2'b00, sq_reg[31:0]} : 34'd0 - {2'b00, sq_reg[31:0]};
    assign e1   = {{3{req.sv[31]}}, req.sv} - {peak[33], peak};
    assign e2   = {peak[33], peak} - {{3{req.gv[31]}}, req.gv};
    assign n1   = e1[34] ? 34'(35'd0 - e1) : e1[33:0];
    assign n2   = e2[34] ? 34'(35'd0 - e2) : e2[33:0];

    assign rtrial = {1'b0, rem_reg} << 1 | 32'(num_reg[63]);
    assign ge     = rtrial >= {1'b0, den_reg};
    assign rem_n  = ge ? 31'(rtrial - {1'b0, den_reg}) : rtrial[30:0];
    assign q_n    = {q_reg[62:0], ge};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            A_IDLE: if (start) state_next = A_SQ1;
            A_SQ1:  state_next = A_SQ2;
            A_SQ2:  state_next = A_AD;
            A_AD:   state_next = A_RAD;
            A_RAD:  state_next = A_SQRT;
            A_SQRT: if (k_reg == 5'd31) state_next = A_NUM;
            A_NUM:  state_next = A_DIV;
            A_DIV:  if (cnt_reg == 6'd63 && dsel_reg == 2'd3) state_next = A_DONE;
            A_DONE: state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            A_SQ1: s2_reg <= mul_p;
            A_SQ2: g2_reg <= mul_p;
            A_AD:
            begin
                ad_reg   <= mul_p;
                half_reg <= 64'(({1'b0, s2_reg} + {1'b0, g2_reg}) >> 1);
            end
            A_RAD:
            begin
                x_reg  <= ad_reg + half_reg;
                sq_reg <= 64'd0;
                k_reg  <= 5'd0;
            end
            A_SQRT:
            begin
                if (x_reg >= trial)
                begin
                    x_reg  <= x_reg - trial;
                    sq_reg <= (sq_reg >> 1) + bitv;
                end
                else
                begin
                    sq_reg <= sq_reg >> 1;
                end
                k_reg <= k_reg + 5'd1;
            end
            A_NUM:
            begin
                n2_reg   <= n2;
                num_reg  <= 64'(n1) << FRAC_BITS;
                den_reg  <= req.acc;
                rem_reg  <= 31'd0;
                q_reg    <= 64'd0;
                cnt_reg  <= 6'd0;
                dsel_reg <= 2'd0;
            end
            A_DIV:
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    rem_reg  <= 31'd0;
                    q_reg    <= 64'd0;
                    dsel_reg <= dsel_reg + 2'd1;
                    case (dsel_reg)
                        2'd0:
                        begin
                            t_reg   <= q_n;
                            num_reg <= q_n;
                            den_reg <= req.dt;
                        end
                        2'd1:
                        begin
                            ts_reg  <= t_reg - 64'(rem_n);
                            num_reg <= 64'(n2_reg) << FRAC_BITS;
                            den_reg <= req.acc;
                        end
                        2'd2:
                        begin
                            t_reg   <= q_n;
                            num_reg <= q_n;
                            den_reg <= req.dt;
                        end
                        default:
                        begin
                            tg_reg <= t_reg - 64'(rem_n);
                        end
                    endcase
                end
                else
                begin
                    rem_reg <= rem_n;
                    q_reg   <= q_n;
                    num_reg <= {num_reg[62:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done    = state_reg == A_DONE;
    assign res.dir = dir;
    assign res.ts  = ts_reg;
    assign res.tg  = tg_reg;

endmodule

/* rtl/bang_bang_steering_2d_unit.sv */
// Top level of the two-axis bang-bang steering planner.
// Depends on bbs_pkg and bbs_axis.
`timescale 1ns / 1ps

// Usage:
//   in channel (in_valid/in_ready/in_data): one query with start and goal position
//   and velocity per axis, Q16.16. in_ready is high only while no query is in work.
//   out channel (out_valid/out_ready/out_data): three plan segments per query, the
//   third with last_segment set. Each segment is held until its transfer.
//   cfg_we/cfg_index/cfg_wdata: write time_step (index 0) or max_accel (index 1)
//   while idle; a value of 0 acts as 1.
//   Work: one axis evaluation does 3 multiplies, 32 square root steps and four
//   64-step divides in the shared axis unit. A query runs two evaluations plus
//   one per bisection round, up to ITER_LIMIT rounds, then sends its segments.
//   A stalled receiver holds the current segment and the block waits.
//   Reset loads the register defaults and returns to idle; no clearing pass.
module bang_bang_steering_2d_unit #(
    parameter int ITER_LIMIT = bbs_pkg::ITER_LIMIT_DEF,
    parameter int FRAC_BITS  = bbs_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bbs_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bbs_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [30:0]        cfg_wdata
);

    localparam int ITER_W = $clog2(ITER_LIMIT + 1);

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_RUN   = 3'd1;
    localparam logic [2:0] T_CHECK = 3'd2;
    localparam logic [2:0] T_SEG   = 3'd3;
    localparam logic [2:0] T_WAIT  = 3'd4;

    localparam logic [1:0] P_INITX = 2'd0;
    localparam logic [1:0] P_INITY = 2'd1;
    localparam logic [1:0] P_BIS   = 2'd2;

    logic [2:0]  state_reg;
    logic [1:0]  phase_reg;
    logic [30:0] time_step_reg, max_accel_reg;
    bbs_pkg::in_item_t  in_reg;
    bbs_pkg::out_item_t out_reg;
    logic        out_valid_reg;
    logic [30:0] dt_reg, accx_reg, accy_reg, acc_run_reg, lo_reg, hi_reg, mid_reg;
    logic [63:0] tsx_reg, tgx_reg, tsy_reg, tgy_reg;
    logic        bx_reg, by_reg, fast_x_reg, sel_y_reg, start_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [1:0]  seg_reg;
    logic [1:0]  status_reg;

    bbs_pkg::axis_req_t req;
    bbs_pkg::axis_res_t res;
    logic        axis_done;

    logic [63:0] totx, toty, rtot, udiff, half, mn, mx, d3, dur;
    logic [31:0] mid_sum;
    logic [30:0] mid;
    logic        x_first, pos_x, pos_y;

    assign req.sx  = sel_y_reg ? in_reg.start_pos_y : in_reg.start_pos_x;
    assign req.sv  = sel_y_reg ? in_reg.start_vel_y : in_reg.start_vel_x;
    assign req.gx  = sel_y_reg ? in_reg.goal_pos_y  : in_reg.goal_pos_x;
    assign req.gv  = sel_y_reg ? in_reg.goal_vel_y  : in_reg.goal_vel_x;
    assign req.acc = acc_run_reg;
    assign req.dt  = dt_reg;

    bbs_axis #(
        .FRAC_BITS(FRAC_BITS)
    ) u_axis (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start_reg),
        .req  (req),
        .done (axis_done),
        .res  (res)
    );

    assign totx    = tsx_reg + tgx_reg;
    assign toty    = tsy_reg + tgy_reg;
    assign rtot    = res.ts + res.tg;
    assign udiff   = totx > toty ? totx - toty : toty - totx;
    assign half    = 64'(({1'b0, dt_reg} + 32'd1) >> 1);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = (mid_sum[31:1] == 31'd0) ? 31'd1 : mid_sum[31:1];

    assign x_first = tsx_reg < tsy_reg;
    assign mn      = x_first ? tsx_reg : tsy_reg;
    assign mx      = x_first ? tsy_reg : tsx_reg;
    assign d3      = totx > mx ? totx - mx : 64'd0;

    always_comb
    begin
        case (seg_reg)
            2'd0:
            begin
                dur   = mn;
                pos_x = bx_reg;
                pos_y = by_reg;
            end
            2'd1:
            begin
                dur   = mx - mn;
                pos_x = x_first ? !bx_reg : bx_reg;
                pos_y = x_first ? by_reg : !by_reg;
            end
            default:
            begin
                dur   = d3;
                pos_x = !bx_reg;
                pos_y = !by_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            phase_reg     <= P_INITX;
            time_step_reg <= bbs_pkg::TIME_STEP_RST;
            max_accel_reg <= bbs_pkg::MAX_ACCEL_RST;
            out_valid_reg <= 1'b0;
            start_reg     <= 1'b0;
            seg_reg       <= 2'd0;
            iter_reg      <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == bbs_pkg::REG_TIME_STEP)
                begin
                    time_step_reg <= cfg_wdata;
                end
                else
                begin
                    max_accel_reg <= cfg_wdata;
                end
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= T_RUN;
                        phase_reg <= P_INITX;
                        start_reg <= 1'b1;
                    end
                end
                T_RUN:
                begin
                    if (axis_done)
                    begin
                        case (phase_reg)
                            P_INITX:
                            begin
                                phase_reg <= P_INITY;
                                start_reg <= 1'b1;
                            end
                            P_INITY:
                            begin
                                state_reg <= T_CHECK;
                                iter_reg  <= '0;
                            end
                            default:
                            begin
                                state_reg <= T_CHECK;
                                iter_reg  <= iter_reg + ITER_W'(1);
                            end
                        endcase
                    end
                end
                T_CHECK:
                begin
                    if (iter_reg < ITER_W'(ITER_LIMIT) && udiff >= half)
                    begin
                        state_reg <= T_RUN;
                        phase_reg <= P_BIS;
                        start_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= T_SEG;
                        seg_reg   <= 2'd0;
                    end
                end
                T_SEG:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= T_WAIT;
                end
                T_WAIT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (seg_reg == 2'd2)
                        begin
                            state_reg <= T_IDLE;
                        end
                        else
                        begin
                            seg_reg   <= seg_reg + 2'd1;
                            state_reg <= T_SEG;
                        end
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            T_IDLE:
            begin
                if (in_valid)
                begin
                    in_reg      <= in_data;
                    dt_reg      <= (time_step_reg == 31'd0) ? 31'd1 : time_step_reg;
                    accx_reg    <= (max_accel_reg == 31'd0) ? 31'd1 : max_accel_reg;
                    accy_reg    <= (max_accel_reg == 31'd0) ? 31'd1 : max_accel_reg;
                    acc_run_reg <= (max_accel_reg == 31'd0) ? 31'd1 : max_accel_reg;
                    hi_reg      <= (max_accel_reg == 31'd0) ? 31'd1 : max_accel_reg;
                    lo_reg      <= 31'd0;
                    sel_y_reg   <= 1'b0;
                end
            end
            T_RUN:
            begin
                if (axis_done)
                begin
                    case (phase_reg)
                        P_INITX:
                        begin
                            tsx_reg   <= res.ts;
                            tgx_reg   <= res.tg;
                            bx_reg    <= res.dir;
                            sel_y_reg <= 1'b1;
                        end
                        P_INITY:
                        begin
                            tsy_reg    <= res.ts;
                            tgy_reg    <= res.tg;
                            by_reg     <= res.dir;
                            fast_x_reg <= totx < rtot;
                        end
                        default:
                        begin
                            if (fast_x_reg)
                            begin
                                tsx_reg <= res.ts;
                                tgx_reg <= res.tg;
                                if (rtot < toty) hi_reg <= mid_reg;
                                else lo_reg <= mid_reg;
                            end
                            else
                            begin
                                tsy_reg <= res.ts;
                                tgy_reg <= res.tg;
                                if (rtot < totx) hi_reg <= mid_reg;
                                else lo_reg <= mid_reg;
                            end
                        end
                    endcase
                end
            end
            T_CHECK:
            begin
                mid_reg     <= mid;
                acc_run_reg <= mid;
                sel_y_reg   <= !fast_x_reg;
                if (iter_reg < ITER_W'(ITER_LIMIT) && udiff >= half)
                begin
                    if (fast_x_reg) accx_reg <= mid;
                    else accy_reg <= mid;
                end
                status_reg <= {1'b0, udiff >= half};
            end
            T_SEG:
            begin
                out_reg.segment_duration <= (dur > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF
                                                                  : dur[30:0];
                out_reg.accel_x <= pos_x ? {1'b0, accx_reg} : 32'd0 - {1'b0, accx_reg};
                out_reg.accel_y <= pos_y ? {1'b0, accy_reg} : 32'd0 - {1'b0, accy_reg};
                out_reg.last_segment <= seg_reg == 2'd2;
                out_reg.status       <= status_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready  = state_reg == T_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* tb/tb_bang_bang_steering_2d_unit.sv */
// Self-checking testbench for bang_bang_steering_2d_unit: sends planner queries,
// predicts the three plan segments of each one and compares every segment transfer.
// Depends on bbs_pkg and the bang_bang_steering_2d_unit RTL.
`timescale 1ns / 1ps

module tb_bang_bang_steering_2d_unit;
    import bbs_pkg::*;

    localparam longint unsigned CYCLE_LIMIT = 64'd30000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [30:0] cfg_wdata;

    logic [30:0]     shadow_step;
    logic [30:0]     shadow_accel;
    out_item_t       segments_due[$];
    int              fail_count;
    longint unsigned cycle_count;
    bit              no_idle;
    int              stall_left;

    bang_bang_steering_2d_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic longint unsigned mag(input longint v);
        return v < 0 ? 64'd0 - longint'(v) : v;
    endfunction

    function automatic longint unsigned int_root(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic bit axis_timing(input longint sx, input longint sv, input longint gx,
                                       input longint gv, input longint unsigned a,
                                       input longint unsigned dt,
                                       output longint unsigned ts, output longint unsigned tg);
        longint unsigned d, s2, g2, rad, n1, n2, t1, t2;
        longint vp, pk;
        bit dir;
        dir = sx < gx;
        d = dir ? longint'(gx - sx) : longint'(sx - gx);
        s2 = mag(sv) * mag(sv);
        g2 = mag(gv) * mag(gv);
        rad = a * d + ((s2 + g2) >> 1);
        vp = int_root(rad);
        pk = dir ? vp : -vp;
        n1 = mag(sv - pk);
        n2 = mag(pk - gv);
        t1 = (n1 << FRAC_BITS_DEF) / a;
        t2 = (n2 << FRAC_BITS_DEF) / a;
        ts = (t1 / dt) * dt;
        tg = (t2 / dt) * dt;
        return dir;
    endfunction

    function automatic logic [30:0] clip_dur(input longint unsigned v);
        return v > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : v[30:0];
    endfunction

    function automatic logic [31:0] signed_accel(input bit pos, input longint unsigned acc);
        return pos ? acc[31:0] : -acc[31:0];
    endfunction

    function automatic void plan_query(input in_item_t q);
        longint px, py, vx, vy, gpx, gpy, gvx, gvy;
        longint unsigned dt, amax, half, tsx, tgx, tsy, tgy, totx, toty;
        longint unsigned accx, accy, lo, hi, mid, mn, mx, d3;
        logic [1:0] st;
        bit bx, by, fast_x, x_first, unused;
        out_item_t seg;
        px = q.start_pos_x;  py = q.start_pos_y;
        vx = q.start_vel_x;  vy = q.start_vel_y;
        gpx = q.goal_pos_x;  gpy = q.goal_pos_y;
        gvx = q.goal_vel_x;  gvy = q.goal_vel_y;
        dt = shadow_step != 0 ? shadow_step : 1;
        amax = shadow_accel != 0 ? shadow_accel : 1;
        half = (dt + 1) >> 1;
        accx = amax;
        accy = amax;
        lo = 0;
        hi = amax;
        st = 2'd0;
        bx = axis_timing(px, vx, gpx, gvx, amax, dt, tsx, tgx);
        by = axis_timing(py, vy, gpy, gvy, amax, dt, tsy, tgy);
        totx = tsx + tgx;
        toty = tsy + tgy;
        fast_x = totx < toty;
        for (int r = 0; r < ITER_LIMIT_DEF; r++)
        begin
            if ((totx > toty ? totx - toty : toty - totx) < half)
                break;
            mid = (lo + hi) >> 1;
            if (mid == 0)
                mid = 1;
            if (fast_x)
            begin
                accx = mid;
                unused = axis_timing(px, vx, gpx, gvx, mid, dt, tsx, tgx);
                totx = tsx + tgx;
                if (totx < toty) hi = mid; else lo = mid;
            end
            else
            begin
                accy = mid;
                unused = axis_timing(py, vy, gpy, gvy, mid, dt, tsy, tgy);
                toty = tsy + tgy;
                if (toty < totx) hi = mid; else lo = mid;
            end
        end
        if ((totx > toty ? totx - toty : toty - totx) >= half)
            st[0] = 1'b1;
        mn = tsx < tsy ? tsx : tsy;
        mx = tsx < tsy ? tsy : tsx;
        d3 = totx > mx ? totx - mx : 0;
        x_first = tsx < tsy;

        seg.segment_duration = clip_dur(mn);
        seg.accel_x = signed_accel(bx, accx);
        seg.accel_y = signed_accel(by, accy);
        seg.last_segment = 1'b0;
        seg.status = st;
        segments_due.push_back(seg);
        seg.segment_duration = clip_dur(mx - mn);
        seg.accel_x = signed_accel(x_first ? !bx : bx, accx);
        seg.accel_y = signed_accel(x_first ? by : !by, accy);
        segments_due.push_back(seg);
        seg.segment_duration = clip_dur(d3);
        seg.accel_x = signed_accel(!bx, accx);
        seg.accel_y = signed_accel(!by, accy);
        seg.last_segment = 1'b1;
        segments_due.push_back(seg);
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[bang_bang_steering_2d_unit] ERROR");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left <= idle_len();
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (segments_due.size() == 0)
            begin
                $error("unexpected segment transfer %h", out_data);
                fail_count++;
            end
            else
            begin
                want = segments_due.pop_front();
                if (out_data.segment_duration !== want.segment_duration)
                begin
                    $error("segment_duration expected %0d actual %0d",
                           want.segment_duration, out_data.segment_duration);
                    fail_count++;
                end
                if (out_data.accel_x !== want.accel_x)
                begin
                    $error("accel_x expected %0d actual %0d", want.accel_x, out_data.accel_x);
                    fail_count++;
                end
                if (out_data.accel_y !== want.accel_y)
                begin
                    $error("accel_y expected %0d actual %0d", want.accel_y, out_data.accel_y);
                    fail_count++;
                end
                if (out_data.last_segment !== want.last_segment)
                begin
                    $error("last_segment expected %0d actual %0d",
                           want.last_segment, out_data.last_segment);
                    fail_count++;
                end
                if (out_data.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, out_data.status);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_query(input in_item_t q);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= q;
        do
            @(posedge clk);
        while (!in_ready);
        plan_query(q);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (segments_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [30:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TIME_STEP)
            shadow_step = val;
        else
            shadow_accel = val;
    endtask

    function automatic logic [31:0] rand_field(input int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
        endcase
    endfunction

    function automatic in_item_t rand_query(input int mode);
        in_item_t q;
        q.start_pos_x = rand_field(mode);
        q.start_pos_y = rand_field(mode);
        q.start_vel_x = rand_field(mode == 0 ? 0 : 2);
        q.start_vel_y = rand_field(mode == 0 ? 0 : 2);
        q.goal_pos_x = rand_field(mode);
        q.goal_pos_y = rand_field(mode);
        q.goal_vel_x = rand_field(mode == 0 ? 0 : 2);
        q.goal_vel_y = rand_field(mode == 0 ? 0 : 2);
        if ($urandom_range(0, 9) == 0)
            q.goal_pos_x = q.start_pos_x;
        if ($urandom_range(0, 9) == 0)
            q.goal_pos_y = q.start_pos_y;
        return q;
    endfunction

    task automatic test_directed();
        in_item_t q;
        q = '0;
        send_query(q);
        q = '1;
        send_query(q);
        q = {8{32'h7FFF_FFFF}};
        send_query(q);
        q = {8{32'h8000_0000}};
        send_query(q);
        q = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        send_query(q);
        q = {32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0,
             32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0};
        send_query(q);
        q = '0;
        q.goal_pos_x = 32'h0001_0000;
        q.goal_pos_y = 32'h0001_0000;
        send_query(q);
        q.goal_pos_y = 32'h0004_0000;
        send_query(q);
        q.goal_pos_x = -32'sh0008_0000;
        q.start_vel_y = 32'h0002_0000;
        send_query(q);
        q = '0;
        q.start_pos_x = 32'h0003_0000;
        q.goal_pos_x = 32'h0003_0000;
        q.goal_pos_y = 32'h0002_0000;
        q.goal_vel_x = 32'h0001_0000;
        send_query(q);
        q = '0;
        q.start_vel_x = 32'h0010_0000;
        q.goal_pos_y = 32'h0000_0001;
        send_query(q);
        q = rand_query(2);
        send_query(q);
    endtask

    task automatic test_config_extremes();
        write_reg(REG_TIME_STEP, 31'd0);
        write_reg(REG_MAX_ACCEL, 31'd0);
        test_directed();
        write_reg(REG_TIME_STEP, 31'h7FFF_FFFF);
        write_reg(REG_MAX_ACCEL, 31'h7FFF_FFFF);
        repeat (4) send_query(rand_query(1));
        send_query({8{32'h7FFF_FFFF}});
        write_reg(REG_TIME_STEP, 31'd1);
        write_reg(REG_MAX_ACCEL, 31'd1);
        repeat (4) send_query(rand_query(2));
        send_query('0);
    endtask

    task automatic test_random_queries(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 9);
            send_query(rand_query(r < 2 ? 0 : (r < 6 ? 1 : 2)));
        end
    endtask

    task automatic test_random_settings();
        write_reg(REG_TIME_STEP, TIME_STEP_RST);
        write_reg(REG_MAX_ACCEL, MAX_ACCEL_RST);
        no_idle = 1'b1;
        test_random_queries(30);
        no_idle = 1'b0;
        test_random_queries(50);
        for (int k = 0; k < 6; k++)
        begin
            write_reg(REG_TIME_STEP, 31'($urandom_range(1, 32'h0001_0000)));
            write_reg(REG_MAX_ACCEL, 31'($urandom));
            test_random_queries(20);
        end
        write_reg(REG_TIME_STEP, 31'($urandom));
        write_reg(REG_MAX_ACCEL, 31'($urandom_range(1, 32'h0010_0000)));
        test_random_queries(10);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_TIME_STEP;
        cfg_wdata = '0;
        fail_count = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        shadow_step = TIME_STEP_RST;
        shadow_accel = MAX_ACCEL_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_random_settings();
        drain();
        if (fail_count == 0)
            $display("[bang_bang_steering_2d_unit] OK");
        else
            $display("[bang_bang_steering_2d_unit] ERROR");
        $finish;
    end
endmodule
